// ----- src/ntf_pkg.sv -----
// Shared types, character codes and roman helper functions for the number formatter.
`timescale 1ns / 1ps
`default_nettype none

package ntf_pkg;

	// Digit store and length sizes.
	localparam int DIG_N        = 10;
	localparam int DIG_W        = 5;
	localparam int LEN_W        = 6;
	localparam int RESULT_LIMIT = 16;
	localparam logic [31:0] ROMAN_MAX = 32'd39999;

	// Input mode codes.
	localparam logic [2:0] MODE_DEC      = 3'd0;
	localparam logic [2:0] MODE_ROMAN_LC = 3'd1;
	localparam logic [2:0] MODE_ROMAN_UC = 3'd2;
	localparam logic [2:0] MODE_ALPHA_LC = 3'd3;
	localparam logic [2:0] MODE_ALPHA_UC = 3'd4;

	// Formatting families after the mode code is decoded.
	typedef enum logic [1:0] {
		KIND_DEC   = 2'd0,
		KIND_ROMAN = 2'd1,
		KIND_ALPHA = 2'd2
	} kind_t;

	// ASCII codes.
	localparam logic [6:0] CH_ZERO    = 7'h30;
	localparam logic [6:0] CH_MINUS   = 7'h2D;
	localparam logic [6:0] CH_LC_A    = 7'h61;
	localparam logic [6:0] CH_UC_A    = 7'h41;
	localparam logic [6:0] CASE_SHIFT = 7'd32;
	localparam logic [6:0] CH_NUL     = 7'h00;

	// Roman letters for the ones of each decimal position (i x c m z) and the fives of the lower four (v l d w).
	localparam logic [6:0] ROMAN_ONES [5] = '{7'h69, 7'h78, 7'h63, 7'h6D, 7'h7A};
	localparam logic [6:0] ROMAN_FIVES [4] = '{7'h76, 7'h6C, 7'h64, 7'h77};

	// Number of roman letters that one decimal digit turns into.
	function automatic logic [2:0] roman_count(input logic [DIG_W-1:0] d);
		logic [DIG_W-1:0] rem;
		logic             hi;
		begin
			hi  = (d >= DIG_W'(5));
			rem = hi ? (d - DIG_W'(5)) : d;
			if (rem == DIG_W'(4)) begin
				roman_count = 3'd2;
			end else begin
				roman_count = 3'(rem) + {2'b00, hi};
			end
		end
	endfunction

	// Roman letter of a digit at a position; first marks the leading letter of that digit.
	function automatic logic [6:0] roman_char(input logic [DIG_W-1:0] d, input logic first,
			input logic [2:0] pos, input logic upper);
		logic [DIG_W-1:0] rem;
		logic             hi;
		logic [2:0]       nxt;
		logic [6:0]       c;
		begin
			hi  = (d >= DIG_W'(5));
			rem = hi ? (d - DIG_W'(5)) : d;
			nxt = (pos == 3'd4) ? 3'd0 : (pos + 3'd1);
			if (rem == DIG_W'(4)) begin
				if (first) begin
					c = ROMAN_ONES[pos];
				end else if (hi) begin
					c = ROMAN_ONES[nxt];
				end else begin
					c = ROMAN_FIVES[pos[1:0]];
				end
			end else if (hi && first) begin
				c = ROMAN_FIVES[pos[1:0]];
			end else begin
				c = ROMAN_ONES[pos];
			end
			roman_char = upper ? (c - CASE_SHIFT) : c;
		end
	endfunction

endpackage

`default_nettype wire

// ----- src/ntf_divider.sv -----
// Shared divider by ten or twenty-six using a registered reciprocal multiply and a combinational fix-up.
`timescale 1ns / 1ps
`default_nettype none

module ntf_divider (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic                          alpha,
	input  wire logic [31:0]                   dividend,
	output logic                               done,
	output logic [31:0]                        quotient,
	output logic [ntf_pkg::DIG_W-1:0]          remainder
);

	// Reciprocals that give exact quotients for any 32-bit dividend.
	localparam logic [31:0] RECIP_DEC   = 32'hCCCC_CCCD;
	localparam logic [31:0] RECIP_ALPHA = 32'h9D89_D89E;
	localparam logic [31:0] BASE_DEC    = 32'd10;
	localparam logic [31:0] BASE_ALPHA  = 32'd26;

	logic        vld_s1;
	logic        alpha_s1;
	logic [31:0] dvd_s1;
	logic [63:0] prod_s1;
	logic [31:0] back;
	logic [31:0] diff;

	// Valid flag of the multiply stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	// Multiply stage: dividend times reciprocal.
	always_ff @(posedge clk) begin
		if (start) begin
			alpha_s1 <= alpha;
			dvd_s1   <= dividend;
			prod_s1  <= 64'(dividend) * 64'(alpha ? RECIP_ALPHA : RECIP_DEC);
		end
	end

	// Fix-up: take the high bits, then the remainder by a constant multiply and subtract.
	always_comb begin
		quotient  = alpha_s1 ? {4'd0, prod_s1[63:36]} : {3'd0, prod_s1[63:35]};
		back      = 32'(quotient * (alpha_s1 ? BASE_ALPHA : BASE_DEC));
		diff      = dvd_s1 - back;
		remainder = diff[ntf_pkg::DIG_W-1:0];
		done      = vld_s1;
	end

endmodule

`default_nettype wire

// ----- src/number_to_text_formatter.sv -----
// Top level of the signed integer to decimal, roman or alphabetic text formatter.
`timescale 1ns / 1ps
`default_nettype none

// Takes one request of mode, minimum digit count and signed value, and returns its text as
// one ASCII character per output request, most significant first, with tlast on the final
// character. One request is worked on at a time and s_tready is high only while the block is
// idle. The magnitude is taken apart by one shared divider unit that works in a reciprocal
// multiply state and then a fix-up state for each digit, so a request passes through the
// accept, the divider states for each digit or letter (at most 10 decimal, 7 alphabetic, 5
// roman), the sizing state, then one emission step per character plus one step for the sign
// position when the value is not negative, one step to leave the padding and, in roman mode,
// one step per digit position. Output stalls lengthen a request. A roman magnitude above
// 39999 returns one result with tuser set and character 0, loaded from the error state into
// the output register.
module number_to_text_formatter #(
	parameter int MAX_CHARS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // [2:0] mode, [7:3] min_digits, [39:8] value
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // [6:0] character, [7] zero
	output logic             m_tlast,
	output logic             m_tuser    // [0] error
);

	localparam int LEN_W = ntf_pkg::LEN_W;
	localparam int DIG_W = ntf_pkg::DIG_W;
	localparam int LIMIT = (MAX_CHARS < ntf_pkg::RESULT_LIMIT) ? MAX_CHARS
		: ntf_pkg::RESULT_LIMIT;

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_DIV_MUL = 6'b000010,
		ST_DIV_FIX = 6'b000100,
		ST_SIZE    = 6'b001000,
		ST_EMIT    = 6'b010000,
		ST_ERR     = 6'b100000
	} state_t;

	typedef enum logic [1:0] {
		PH_SIGN = 2'd0,
		PH_PAD  = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	state_t               state_q;
	phase_t               ph_q;
	phase_t               ph_d;
	ntf_pkg::kind_t       kind_q;
	ntf_pkg::kind_t       in_kind;
	logic                 upper_q;
	logic                 neg_q;
	logic                 zero_q;
	logic [4:0]           mind_q;
	logic [31:0]          v_q;
	logic [DIG_W-1:0]     dig_q [ntf_pkg::DIG_N];
	logic [3:0]           n_q;
	logic [4:0]           rlen_q;
	logic [LEN_W-1:0]     len_q;
	logic [LEN_W-1:0]     cnt_q;
	logic [4:0]           pad_q;
	logic [4:0]           pad_d;
	logic [3:0]           pos_q;
	logic [3:0]           pos_d;
	logic [2:0]           sub_q;
	logic [2:0]           sub_d;
	logic                 m_tvalid_q;
	logic [6:0]           chr_q;
	logic                 last_q;
	logic                 err_q;

	logic [31:0]          in_raw;
	logic                 in_neg;
	logic [31:0]          in_mag;
	logic                 in_upper;
	logic                 in_ovf;
	logic                 in_zero;
	logic                 accept;

	logic                 div_start;
	logic                 div_done;
	logic [31:0]          div_quot;
	logic [DIG_W-1:0]     div_rem;

	logic [4:0]           body_len;
	logic [4:0]           n_ext;
	logic [LEN_W-1:0]     raw_len;

	logic [DIG_W-1:0]     dig_rd;
	logic [2:0]           rc;
	logic                 e_have;
	logic [6:0]           e_chr;
	logic                 e_last;
	logic                 out_free;
	logic                 out_load;

	// Input request decode.
	always_comb begin
		in_raw   = s_tdata[39:8];
		in_neg   = in_raw[31];
		in_mag   = in_neg ? (32'd0 - in_raw) : in_raw;
		unique case (s_tdata[2:0]) inside
			ntf_pkg::MODE_ROMAN_LC, ntf_pkg::MODE_ROMAN_UC: in_kind = ntf_pkg::KIND_ROMAN;
			ntf_pkg::MODE_ALPHA_LC, ntf_pkg::MODE_ALPHA_UC: in_kind = ntf_pkg::KIND_ALPHA;
			default:                                        in_kind = ntf_pkg::KIND_DEC;
		endcase
		in_upper = (s_tdata[2:0] == ntf_pkg::MODE_ROMAN_UC)
			|| (s_tdata[2:0] == ntf_pkg::MODE_ALPHA_UC);
		in_ovf   = (in_kind == ntf_pkg::KIND_ROMAN) && (in_mag > ntf_pkg::ROMAN_MAX);
		in_zero  = (in_kind != ntf_pkg::KIND_DEC) && (in_mag == 32'd0);
		accept   = (state_q == ST_IDLE) && s_tvalid;
	end

	assign s_tready = (state_q == ST_IDLE);

	// Shared divider.
	assign div_start = (state_q == ST_DIV_MUL);

	ntf_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.alpha     (kind_q == ntf_pkg::KIND_ALPHA),
		.dividend  (v_q),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	// Text length once all digits are known.
	always_comb begin
		n_ext = {1'b0, n_q};
		case (kind_q)
			ntf_pkg::KIND_ROMAN: body_len = rlen_q;
			ntf_pkg::KIND_ALPHA: body_len = n_ext;
			default:             body_len = (mind_q > n_ext) ? mind_q : n_ext;
		endcase
		if (zero_q) begin
			body_len = 5'd1;
		end
		raw_len = LEN_W'(body_len) + LEN_W'(neg_q);
	end

	// Next character of the text and the cursor step that goes with it.
	always_comb begin
		dig_rd = dig_q[pos_q];
		rc     = ntf_pkg::roman_count(dig_rd);
		e_have = 1'b0;
		e_chr  = ntf_pkg::CH_ZERO;
		ph_d   = ph_q;
		pad_d  = pad_q;
		pos_d  = pos_q;
		sub_d  = sub_q;
		case (ph_q)
			PH_SIGN: begin
				e_have = neg_q;
				e_chr  = ntf_pkg::CH_MINUS;
				ph_d   = PH_PAD;
			end
			PH_PAD: begin
				if (pad_q != 5'd0) begin
					e_have = 1'b1;
					pad_d  = pad_q - 5'd1;
				end else begin
					ph_d = PH_BODY;
				end
			end
			PH_BODY: begin
				if (zero_q) begin
					e_have = 1'b1;
				end else begin
					case (kind_q)
						ntf_pkg::KIND_ALPHA: begin
							e_have = 1'b1;
							e_chr  = (upper_q ? ntf_pkg::CH_UC_A : ntf_pkg::CH_LC_A)
								+ 7'(dig_rd);
							pos_d  = pos_q - 4'd1;
						end
						ntf_pkg::KIND_ROMAN: begin
							if (sub_q == rc) begin
								pos_d = pos_q - 4'd1;
								sub_d = 3'd0;
							end else begin
								e_have = 1'b1;
								e_chr  = ntf_pkg::roman_char(dig_rd, sub_q == 3'd0,
									pos_q[2:0], upper_q);
								sub_d  = sub_q + 3'd1;
							end
						end
						default: begin
							e_have = 1'b1;
							e_chr  = ntf_pkg::CH_ZERO + 7'(dig_rd);
							pos_d  = pos_q - 4'd1;
						end
					endcase
				end
			end
			default: ;
		endcase
		e_last   = ((cnt_q + LEN_W'(1)) == len_q);
		out_free = !m_tvalid_q || m_tready;
		out_load = out_free && (((state_q == ST_EMIT) && e_have) || (state_q == ST_ERR));
	end

	// Sequencer and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						if (in_ovf) begin
							state_q <= ST_ERR;
						end else if (in_zero) begin
							state_q <= ST_SIZE;
						end else begin
							state_q <= ST_DIV_MUL;
						end
					end
				end
				ST_DIV_MUL: state_q <= ST_DIV_FIX;
				ST_DIV_FIX: begin
					if (div_done) begin
						state_q <= (div_quot == 32'd0) ? ST_SIZE : ST_DIV_MUL;
					end
				end
				ST_SIZE: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (out_free && e_have && e_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_ERR: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working registers: request fields, digit store and emission cursor.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= in_kind;
			upper_q <= in_upper;
			neg_q   <= in_neg;
			mind_q  <= s_tdata[7:3];
			zero_q  <= in_zero;
			v_q     <= (in_kind == ntf_pkg::KIND_ALPHA) ? (in_mag - 32'd1) : in_mag;
			n_q     <= 4'd0;
			rlen_q  <= 5'd0;
		end
		if ((state_q == ST_DIV_FIX) && div_done) begin
			dig_q[n_q] <= div_rem;
			n_q        <= n_q + 4'd1;
			rlen_q     <= rlen_q + 5'(ntf_pkg::roman_count(div_rem));
			v_q        <= (kind_q == ntf_pkg::KIND_ALPHA) ? (div_quot - 32'd1) : div_quot;
		end
		if (state_q == ST_SIZE) begin
			len_q <= (raw_len > LEN_W'(LIMIT)) ? LEN_W'(LIMIT) : raw_len;
			pad_q <= ((kind_q == ntf_pkg::KIND_DEC) && (mind_q > n_ext)) ? (mind_q - n_ext)
				: 5'd0;
			pos_q <= n_q - 4'd1;
			sub_q <= 3'd0;
			ph_q  <= PH_SIGN;
			cnt_q <= '0;
		end
		if ((state_q == ST_EMIT) && out_free) begin
			ph_q  <= ph_d;
			pad_q <= pad_d;
			pos_q <= pos_d;
			sub_q <= sub_d;
			if (e_have) begin
				cnt_q <= cnt_q + LEN_W'(1);
			end
		end
		if (out_load) begin
			chr_q  <= (state_q == ST_ERR) ? ntf_pkg::CH_NUL : e_chr;
			last_q <= (state_q == ST_ERR) ? 1'b1 : e_last;
			err_q  <= (state_q == ST_ERR);
		end
	end

	// Output register drives the result channel.
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, chr_q};
	assign m_tlast  = last_q;
	assign m_tuser  = err_q;

endmodule

`default_nettype wire
